### rtl/core/s3e_pkg.sv
package s3e_pkg;

    // internal fixed point: q.40 values, q.30 angles
    localparam int IW        = 40;
    localparam int AW        = 30;
    localparam int ZW        = 36;
    localparam int MUL_LAT   = 3;
    localparam int SQ_CELLS  = 60;
    localparam int MAX_STEPS = 62;

    typedef logic signed [63:0] word_t;

    typedef struct packed {
        word_t                x;
        word_t                y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [63:0]         mag;
        logic [63:0]         rem;
        logic [SQ_CELLS-1:0] root;
    } sqrt_t;

    localparam logic [63:0] PROD_LIMIT = 64'd1 << 56;

    localparam word_t GAIN_Q30      = 64'sd652032874;
    localparam word_t INV_SQRT3_Q30 = 64'sd619925131;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam word_t Q_3_2  = word_t'(64'd3 << (IW - 1));
    localparam word_t Q_27_2 = word_t'(64'd27 << (IW - 1));
    localparam word_t Q_27_4 = word_t'(64'd27 << (IW - 2));
    localparam word_t Q_1_4  = word_t'(64'd1 << (IW - 2));

    // reciprocals of three, exact below 2^33 and 2^35
    localparam logic [31:0] DIV3_M33 = 32'd2863311531;
    localparam logic [33:0] DIV3_M35 = 34'd11453246123;

    function automatic logic signed [ZW-1:0] atan_at(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        if (i < 11)
        begin
            unique case (i)
                0:       r = 36'sd843314856;
                1:       r = 36'sd497837829;
                2:       r = 36'sd263043836;
                3:       r = 36'sd133525158;
                4:       r = 36'sd67021686;
                5:       r = 36'sd33543515;
                6:       r = 36'sd16775850;
                7:       r = 36'sd8388437;
                8:       r = 36'sd4194282;
                9:       r = 36'sd2097149;
                default: r = 36'sd1048575;
            endcase
        end
        else if (i < AW)
        begin
            r = ZW'((64'd1 << (AW - i)) - 64'd1);
        end
        return r;
    endfunction

endpackage

### rtl/core/s3e_delay.sv
module s3e_delay #(
    parameter int W     = 64,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

### rtl/core/s3e_mul.sv
module s3e_mul #(
    parameter int SH = 40
) (
    input  logic           clk,
    input  logic           en,
    input  s3e_pkg::word_t a,
    input  s3e_pkg::word_t b,
    output s3e_pkg::word_t p
);
    import s3e_pkg::*;

    logic [63:0] ma_reg, mb_reg;
    logic        neg1_reg, neg2_reg;
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    word_t       p_reg;

    logic [127:0] full;
    logic [127:0] shr;
    logic [63:0]  mag;

    // magnitudes, then four 32x32 partial products, then shift and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= a[63] ? 64'(-a) : 64'(a);
            mb_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg1_reg <= a[63] ^ b[63];
            ll_reg   <= 64'(ma_reg[31:0])  * 64'(mb_reg[31:0]);
            lh_reg   <= 64'(ma_reg[31:0])  * 64'(mb_reg[63:32]);
            hl_reg   <= 64'(ma_reg[63:32]) * 64'(mb_reg[31:0]);
            hh_reg   <= 64'(ma_reg[63:32]) * 64'(mb_reg[63:32]);
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? word_t'(-mag) : word_t'(mag);
        end
    end

    always_comb
    begin
        full = {64'b0, ll_reg} + {32'b0, lh_reg, 32'b0} + {32'b0, hl_reg, 32'b0}
             + {hh_reg, 64'b0};
        shr  = full >> SH;
        mag  = (shr > 128'(PROD_LIMIT)) ? PROD_LIMIT : shr[63:0];
    end

    assign p = p_reg;

endmodule

### rtl/core/s3e_sqrt_cell.sv
module s3e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           en,
    input  s3e_pkg::sqrt_t d,
    output s3e_pkg::sqrt_t q
);
    import s3e_pkg::*;

    localparam int J0 = 2 * K - IW;
    localparam int J1 = J0 + 1;

    sqrt_t       q_reg;
    logic        b0, b1;
    logic [63:0] rem_sh, trial;

    // operand is the magnitude shifted up by the fraction width
    if (J0 >= 0 && J0 < 64)
    begin : g_b0
        assign b0 = d.mag[J0];
    end
    else
    begin : g_b0z
        assign b0 = 1'b0;
    end

    if (J1 >= 0 && J1 < 64)
    begin : g_b1
        assign b1 = d.mag[J1];
    end
    else
    begin : g_b1z
        assign b1 = 1'b0;
    end

    always_comb
    begin
        rem_sh = {d.rem[61:0], b1, b0};
        trial  = {2'b0, d.root, 2'b01};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg.mag <= d.mag;
            if (rem_sh >= trial)
            begin
                q_reg.rem  <= rem_sh - trial;
                q_reg.root <= {d.root[SQ_CELLS-2:0], 1'b1};
            end
            else
            begin
                q_reg.rem  <= rem_sh;
                q_reg.root <= {d.root[SQ_CELLS-2:0], 1'b0};
            end
        end
    end

    assign q = q_reg;

endmodule

### rtl/core/s3e_cordic_cell.sv
module s3e_cordic_cell #(
    parameter bit ROTATE = 1'b0,
    parameter int IDX    = 0
) (
    input  logic             clk,
    input  logic             en,
    input  s3e_pkg::cordic_t d,
    output s3e_pkg::cordic_t q
);
    import s3e_pkg::*;

    localparam logic signed [ZW-1:0] ANG = atan_at(IDX);

    cordic_t q_reg;
    word_t   xs, ys;
    logic    turn_neg;

    // turn_neg: x - y/2^i, y + x/2^i, z - angle
    always_comb
    begin
        xs       = d.x >>> IDX;
        ys       = d.y >>> IDX;
        turn_neg = ROTATE ? !d.z[ZW-1] : !(d.y > 64'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (turn_neg)
            begin
                q_reg.x <= d.x - ys;
                q_reg.y <= d.y + xs;
                q_reg.z <= d.z - ANG;
            end
            else
            begin
                q_reg.x <= d.x + ys;
                q_reg.y <= d.y - xs;
                q_reg.z <= d.z + ANG;
            end
        end
    end

    assign q = q_reg;

endmodule

### rtl/core/symmetric_3x3_eigenvalues_core.sv
// eigenvalues of a symmetric 3x3 matrix by the trigonometric cardano form. each input
// transfer carries the upper triangle of one matrix as signed q16.16 entries and gives one
// output transfer with the three eigenvalues, rounded to nearest and clamped to 32 bits, and
// a flag that is set when any of them was clamped. the entries are first scaled by a common
// power of two, then the polynomial coefficients, two 60-cell square root chains and two
// cordic chains (vectoring for the angle, rotation for cos and sin) do the work. the block
// is a full pipeline: it takes one matrix every clock cycle while the output is not held
// with a full last stage, and each matrix passes the normalisation, polynomial, square
// root, cordic and eigenvalue registers in that order. a held result in the output
// register does not stop the pipeline while its last stage is empty.
module symmetric_3x3_eigenvalues_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // diag_xx, diag_yy, diag_zz, off_xy, off_yz, off_xz
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // eig_first, eig_second, eig_third
    output logic         m_axis_tuser    // saturated
);
    import s3e_pkg::*;

    localparam int N = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    // pipeline timing, in registers after the input ports
    localparam int T_N   = 2;
    localparam int T_M   = T_N + 1;
    localparam int T_L1  = T_N + MUL_LAT;
    localparam int T_C1  = T_L1 + 1;
    localparam int T_L2  = T_L1 + MUL_LAT;
    localparam int T_PC  = T_L2 + 1;
    localparam int T_V   = T_PC + 1;
    localparam int T_L4  = T_PC + MUL_LAT;
    localparam int T_U1  = T_L4 + 1;
    localparam int T_L5  = T_U1 + MUL_LAT;
    localparam int T_Q   = T_L5 + 1;
    localparam int T_L7  = T_Q + MUL_LAT;
    localparam int T_T   = T_L7 + 1;
    localparam int T_PHI = T_T + 1;
    localparam int T_SQ  = T_PHI + SQ_CELLS;
    localparam int T_VS  = T_SQ + 1;
    localparam int T_VE  = T_VS + N;
    localparam int T_ZP  = T_VE + 1;
    localparam int T_ZD  = T_ZP + 1;
    localparam int T_RE  = T_ZD + N;
    localparam int T_SS  = T_RE + MUL_LAT;
    localparam int T_D   = T_SS + 1;
    localparam int T_QA  = T_D + 1;
    localparam int T_W1  = T_QA + 1;
    localparam int T_OUT = T_W1 + 1;

    localparam word_t MAX32 = 64'sd2147483647;
    localparam word_t MIN32 = -64'sd2147483648;

    // ---------------- flow control ----------------
    logic             en;
    logic             load;
    logic [T_OUT:1]   vld_reg;
    logic             out_vld_reg;
    logic [95:0]      out_data_reg;
    logic             out_sat_reg;

    // output register refills when empty or when its transfer completes
    assign load          = !out_vld_reg || m_axis_tready;
    assign en            = load || !vld_reg[T_OUT];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[T_OUT-1:1], s_axis_tvalid};
            end
            if (load)
            begin
                out_vld_reg <= vld_reg[T_OUT];
            end
        end
    end

    // ---------------- normalisation ----------------
    logic signed [31:0] raw      [6];
    logic signed [31:0] raw_reg  [6];
    logic [5:0]         sh_reg;
    logic [5:0]         sh_w1;
    word_t              n_reg    [6];
    logic [32:0]        or_mag;
    logic [5:0]         blen;
    logic signed [32:0] ext;

    // bit length of the largest magnitude equals that of the or of all magnitudes
    always_comb
    begin
        or_mag = '0;
        for (int i = 0; i < 6; i++)
        begin
            raw[i] = s_axis_tdata[32*i +: 32];
            ext    = {raw[i][31], raw[i]};
            or_mag = or_mag | (ext[32] ? 33'(-ext) : 33'(ext));
        end
        blen = '0;
        for (int k = 0; k < 33; k++)
        begin
            if (or_mag[k])
            begin
                blen = 6'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                raw_reg[i] <= raw[i];
                n_reg[i]   <= word_t'(raw_reg[i]) <<< sh_reg;
            end
            sh_reg <= 6'(IW) - blen;
        end
    end

    // ---------------- characteristic polynomial ----------------
    word_t de, dd, e2, ff, ab, ac, bc;
    word_t m_reg, m5, m13, m_ss;
    word_t a5, b5, c5, f5;
    word_t cdd, ae2, bff, abc, fde, mm;
    word_t c1_reg, c1_8, c1_9;
    word_t p_reg, c0_reg, v_reg, u1_reg;
    word_t k1, k2, k3, c1sq, c1sq13, k2_16, k3_16;
    word_t mu, qq1, qq1_17, v17, c0_17, p12, p22;
    word_t q_reg, qk_reg, t1, t2, t_reg, phi_reg;

    s3e_mul u_de (.clk, .en, .a(n_reg[3]), .b(n_reg[4]), .p(de));
    s3e_mul u_dd (.clk, .en, .a(n_reg[3]), .b(n_reg[3]), .p(dd));
    s3e_mul u_e2 (.clk, .en, .a(n_reg[4]), .b(n_reg[4]), .p(e2));
    s3e_mul u_ff (.clk, .en, .a(n_reg[5]), .b(n_reg[5]), .p(ff));
    s3e_mul u_ab (.clk, .en, .a(n_reg[0]), .b(n_reg[1]), .p(ab));
    s3e_mul u_ac (.clk, .en, .a(n_reg[0]), .b(n_reg[2]), .p(ac));
    s3e_mul u_bc (.clk, .en, .a(n_reg[1]), .b(n_reg[2]), .p(bc));

    s3e_delay #(.W(256), .DEPTH(T_L1 - T_N)) u_dl_abcf (
        .clk, .en,
        .d({n_reg[0], n_reg[1], n_reg[2], n_reg[5]}),
        .q({a5, b5, c5, f5})
    );
    s3e_delay #(.W(64), .DEPTH(T_L1 - T_M)) u_dl_m5 (.clk, .en, .d(m_reg), .q(m5));

    s3e_mul u_cdd (.clk, .en, .a(c5), .b(dd), .p(cdd));
    s3e_mul u_ae2 (.clk, .en, .a(a5), .b(e2), .p(ae2));
    s3e_mul u_bff (.clk, .en, .a(b5), .b(ff), .p(bff));
    s3e_mul u_abc (.clk, .en, .a(ab), .b(c5), .p(abc));
    s3e_mul u_fde (.clk, .en, .a(f5), .b(de), .p(fde));
    s3e_mul u_mm  (.clk, .en, .a(m5), .b(m5), .p(mm));

    s3e_delay #(.W(64), .DEPTH(T_L2 - T_C1)) u_dl_c1a (.clk, .en, .d(c1_reg), .q(c1_8));
    s3e_delay #(.W(64), .DEPTH(T_PC - T_L2)) u_dl_c1b (.clk, .en, .d(c1_8), .q(c1_9));

    s3e_mul u_k1   (.clk, .en, .a(Q_3_2),  .b(c1_9),   .p(k1));
    s3e_mul u_k2   (.clk, .en, .a(Q_27_2), .b(c0_reg), .p(k2));
    s3e_mul u_c1sq (.clk, .en, .a(c1_9),   .b(c1_9),   .p(c1sq));
    s3e_mul u_k3   (.clk, .en, .a(Q_27_4), .b(c0_reg), .p(k3));

    s3e_delay #(.W(64), .DEPTH(T_L4 - T_PC)) u_dl_p12 (.clk, .en, .d(p_reg), .q(p12));
    s3e_delay #(.W(64), .DEPTH(T_U1 - T_M)) u_dl_m13 (.clk, .en, .d(m_reg), .q(m13));
    s3e_delay #(.W(64), .DEPTH(T_U1 - T_L4)) u_dl_c1sq (.clk, .en, .d(c1sq), .q(c1sq13));

    s3e_mul u_mu  (.clk, .en, .a(m13),   .b(u1_reg), .p(mu));
    s3e_mul u_qq1 (.clk, .en, .a(Q_1_4), .b(c1sq13), .p(qq1));

    s3e_delay #(.W(128), .DEPTH(T_L5 - T_L4)) u_dl_k23 (
        .clk, .en, .d({k2, k3}), .q({k2_16, k3_16})
    );
    s3e_delay #(.W(64), .DEPTH(T_Q - T_L5)) u_dl_qq1 (.clk, .en, .d(qq1), .q(qq1_17));
    s3e_delay #(.W(64), .DEPTH(T_Q - T_V)) u_dl_v17 (.clk, .en, .d(v_reg), .q(v17));
    s3e_delay #(.W(64), .DEPTH(T_Q - T_PC)) u_dl_c0 (.clk, .en, .d(c0_reg), .q(c0_17));

    s3e_mul u_t1 (.clk, .en, .a(qq1_17), .b(v17),    .p(t1));
    s3e_mul u_t2 (.clk, .en, .a(c0_17),  .b(qk_reg), .p(t2));

    s3e_delay #(.W(64), .DEPTH(T_PHI - T_L4)) u_dl_p22 (.clk, .en, .d(p12), .q(p22));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= n_reg[0] + n_reg[1] + n_reg[2];
            c1_reg  <= ab + ac + bc - (dd + e2 + ff);
            p_reg   <= mm - 3 * c1_8;
            c0_reg  <= cdd + ae2 + bff - abc - 2 * fde;
            v_reg   <= p_reg - c1_9;
            u1_reg  <= p12 - k1;
            q_reg   <= mu - k2_16;
            qk_reg  <= mu - k2_16 + k3_16;
            t_reg   <= t1 + t2;
            // times 27 as 16 + 8 + 2 + 1
            phi_reg <= (t_reg <<< 4) + (t_reg <<< 3) + (t_reg <<< 1) + t_reg;
        end
    end

    // ---------------- square root chains ----------------
    sqrt_t phi_chain [SQ_CELLS+1];
    sqrt_t p_chain   [SQ_CELLS+1];

    assign phi_chain[0] = '{mag: phi_reg[63] ? 64'(-phi_reg) : 64'(phi_reg), rem: '0, root: '0};
    assign p_chain[0]   = '{mag: p22[63] ? 64'(-p22) : 64'(p22), rem: '0, root: '0};

    for (genvar j = 0; j < SQ_CELLS; j++)
    begin : g_sqrt
        s3e_sqrt_cell #(.K(SQ_CELLS - 1 - j)) u_phi (
            .clk, .en, .d(phi_chain[j]), .q(phi_chain[j+1])
        );
        s3e_sqrt_cell #(.K(SQ_CELLS - 1 - j)) u_p (
            .clk, .en, .d(p_chain[j]), .q(p_chain[j+1])
        );
    end

    // ---------------- vectoring: angle of (q, sqrt|phi|) ----------------
    word_t   q82, root_phi, root_p, x0, x0_d;
    cordic_t vpre_reg;
    cordic_t vec_chain [N+1];

    s3e_delay #(.W(64), .DEPTH(T_SQ - T_Q)) u_dl_q82 (.clk, .en, .d(q_reg), .q(q82));

    assign root_phi = word_t'({4'b0, phi_chain[SQ_CELLS].root});
    assign root_p   = word_t'({4'b0, p_chain[SQ_CELLS].root});

    // negative q: turn the vector by a quarter circle first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q82[63])
            begin
                vpre_reg.x <= root_phi;
                vpre_reg.y <= -q82;
                vpre_reg.z <= HALF_PI_Q30;
            end
            else
            begin
                vpre_reg.x <= q82;
                vpre_reg.y <= root_phi;
                vpre_reg.z <= '0;
            end
        end
    end

    assign vec_chain[0] = vpre_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        s3e_cordic_cell #(.ROTATE(1'b0), .IDX(i)) u_cell (
            .clk, .en, .d(vec_chain[i]), .q(vec_chain[i+1])
        );
    end

    // rotation start radius sqrt(p) times the inverse cordic gain
    s3e_mul #(.SH(AW)) u_gain (.clk, .en, .a(root_p), .b(GAIN_Q30), .p(x0));
    s3e_delay #(.W(64), .DEPTH(T_ZP - (T_SQ + MUL_LAT))) u_dl_x0 (
        .clk, .en, .d(x0), .q(x0_d)
    );

    // ---------------- angle / 3, truncated toward zero ----------------
    logic signed [ZW-1:0] zv, zm;
    logic [64:0]          zprod_reg;
    logic                 zneg_reg;
    logic [31:0]          zq;
    cordic_t              rot0_reg;
    cordic_t              rot_chain [N+1];

    always_comb
    begin
        zv = vec_chain[N].z;
        zm = zv[ZW-1] ? -zv : zv;
        zq = zprod_reg[64:33];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zprod_reg  <= 65'(zm[32:0]) * 65'(DIV3_M33);
            zneg_reg   <= zv[ZW-1];
            rot0_reg.x <= x0_d;
            rot0_reg.y <= '0;
            rot0_reg.z <= zneg_reg ? -ZW'(zq) : ZW'(zq);
        end
    end

    assign rot_chain[0] = rot0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        s3e_cordic_cell #(.ROTATE(1'b1), .IDX(i)) u_cell (
            .clk, .en, .d(rot_chain[i]), .q(rot_chain[i+1])
        );
    end

    // ---------------- eigenvalues ----------------
    word_t       ss, cc_ss, cc_w, ss_w, d_reg, w1_reg;
    logic [63:0] dmag;
    logic [63:0] hprod;
    logic [31:0] qh;
    logic [33:0] three_qh;
    logic [31:0] qh_reg, lo_reg;
    logic [1:0]  rh_reg;
    logic        dneg_reg;
    logic [67:0] lprod;
    logic [63:0] qfull;

    s3e_mul #(.SH(AW)) u_ss (
        .clk, .en, .a(rot_chain[N].y), .b(INV_SQRT3_Q30), .p(ss)
    );
    s3e_delay #(.W(64), .DEPTH(T_SS - T_RE)) u_dl_cc (
        .clk, .en, .d(rot_chain[N].x), .q(cc_ss)
    );
    s3e_delay #(.W(64), .DEPTH(T_SS - T_U1)) u_dl_mss (.clk, .en, .d(m13), .q(m_ss));
    s3e_delay #(.W(128), .DEPTH(T_W1 - T_SS)) u_dl_ccss (
        .clk, .en, .d({cc_ss, ss}), .q({cc_w, ss_w})
    );
    s3e_delay #(.W(6), .DEPTH(T_W1 - 1)) u_dl_sh (.clk, .en, .d(sh_reg), .q(sh_w1));

    // (m - c) / 3 in two halves: high word first, its remainder carried into the low word
    always_comb
    begin
        dmag     = d_reg[63] ? 64'(-d_reg) : 64'(d_reg);
        hprod    = 64'(dmag[63:32]) * 64'(DIV3_M33);
        qh       = 32'(hprod[63:33]);
        three_qh = {1'b0, qh, 1'b0} + 34'(qh);
        lprod    = 68'({rh_reg, lo_reg}) * 68'(DIV3_M35);
        qfull    = {qh_reg, 32'b0} + 64'(lprod[67:35]);
    end

    function automatic logic [32:0] round_clamp(input word_t w, input logic [5:0] sh);
        word_t       rnd;
        word_t       r;
        logic [32:0] res;
        rnd = w + (word_t'(1) <<< (sh - 6'd1));
        r   = rnd >>> sh;
        if (r > MAX32)
        begin
            res = {1'b1, 32'h7fff_ffff};
        end
        else if (r < MIN32)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, r[31:0]};
        end
        return res;
    endfunction

    logic [32:0] eig1, eig2, eig3;
    logic [31:0] eig1_reg, eig2_reg, eig3_reg;
    logic        sat_reg;

    always_comb
    begin
        eig1 = round_clamp(w1_reg + cc_w, sh_w1);
        eig2 = round_clamp(w1_reg - ss_w, sh_w1);
        eig3 = round_clamp(w1_reg + ss_w, sh_w1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= m_ss - cc_ss;
            qh_reg   <= qh;
            rh_reg   <= 2'(34'(dmag[63:32]) - three_qh);
            lo_reg   <= dmag[31:0];
            dneg_reg <= d_reg[63];
            w1_reg   <= dneg_reg ? word_t'(-qfull) : word_t'(qfull);
            eig1_reg <= eig1[31:0];
            eig2_reg <= eig2[31:0];
            eig3_reg <= eig3[31:0];
            sat_reg  <= eig1[32] | eig2[32] | eig3[32];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {eig3_reg, eig2_reg, eig1_reg};
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
